FILE: src/bb3_pkg.sv
// types and constants shared by the 3x3 box blur block
`default_nettype none

package bb3_pkg;

  // one packed rgb888 pixel, red in the top byte
  typedef logic [23:0] pix_t;

  // line memory word: {row two above, row one above}
  localparam int unsigned LINE_W = 2 * $bits(pix_t);

  // input item
  typedef struct packed {
    logic       cmd;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end;
  } out_item_t;

  // per-item control handed from the position logic to the window
  typedef struct packed {
    logic has_res;
    logic frame_end;
    logic row0_ok;
    logic row2_ok;
    logic col0_ok;
    logic col2_ok;
  } tap_ctrl_t;

  // output queue geometry
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // register port
  localparam int unsigned CFG_AW           = 3;
  localparam logic        REG_IMAGE_WIDTH  = 1'b0;
  localparam logic        REG_IMAGE_HEIGHT = 1'b1;
  localparam logic [10:0] WIDTH_RESET      = 11'd640;
  localparam logic [15:0] HEIGHT_RESET     = 16'd480;

  // row counter ceiling
  localparam logic [15:0] ROW_MAX = 16'hFFFF;

endpackage

`default_nettype wire

FILE: src/bb3_line_ram.sv
// single-port-write, single-port-read line memory with registered read data
`default_nettype none

module bb3_line_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 48,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and read, read returns the old word on an address collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: src/bb3_window.sv
// 3x3 window shift register, edge tap replacement and per-channel sum
`default_nettype none

module bb3_window import bb3_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      shift_i,
  input  tap_ctrl_t ctrl_i,
  input  pix_t      above2_i,
  input  pix_t      above1_i,
  input  pix_t      pix_i,
  output logic      res_valid_o,
  output out_item_t res_o
);

  pix_t      win_q [9];
  pix_t      win_d [9];
  logic      s2_v_q;
  tap_ctrl_t s2_ctrl_q;
  logic [8:0] sum_r;
  logic [8:0] sum_g;
  logic [8:0] sum_b;

  // shift one column left, new column enters on the right
  always_comb begin
    win_d = win_q;
    if (shift_i) begin
      win_d[0] = win_q[1];
      win_d[1] = win_q[2];
      win_d[2] = above2_i;
      win_d[3] = win_q[4];
      win_d[4] = win_q[5];
      win_d[5] = above1_i;
      win_d[6] = win_q[7];
      win_d[7] = win_q[8];
      win_d[8] = pix_i;
    end
  end

  // window and result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
      s2_v_q <= 1'b0;
    end else begin
      win_q  <= win_d;
      s2_v_q <= shift_i && ctrl_i.has_res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      s2_ctrl_q <= ctrl_i;
    end
  end

  // taps outside the image fall back to the centre, each tap weighs 1/8
  always_comb begin
    logic ok;
    pix_t tap;
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        ok = (r != 0 || s2_ctrl_q.row0_ok) && (r != 2 || s2_ctrl_q.row2_ok) &&
             (c != 0 || s2_ctrl_q.col0_ok) && (c != 2 || s2_ctrl_q.col2_ok);
        tap = ok ? win_q[r * 3 + c] : win_q[4];
        sum_r = sum_r + 9'(tap[23:19]);
        sum_g = sum_g + 9'(tap[15:11]);
        sum_b = sum_b + 9'(tap[7:3]);
      end
    end
  end

  // saturate at full scale
  always_comb begin
    res_o.red_out   = sum_r[8] ? 8'hFF : sum_r[7:0];
    res_o.green_out = sum_g[8] ? 8'hFF : sum_g[7:0];
    res_o.blue_out  = sum_b[8] ? 8'hFF : sum_b[7:0];
    res_o.frame_end = s2_ctrl_q.frame_end;
  end

  assign res_valid_o = s2_v_q;

endmodule

`default_nettype wire

FILE: src/bb3_out_fifo.sv
// small result queue that separates the pipeline from the output stall
`default_nettype none

module bb3_out_fifo import bb3_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  out_item_t          push_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o,
  output logic [FIFO_CW-1:0] count_o
);

  out_item_t          slot_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q;
  logic [FIFO_AW-1:0] rd_q;
  logic [FIFO_CW-1:0] cnt_q;
  logic               pop;

  assign pop = (cnt_q != '0) && !out_stall_i;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + FIFO_AW'(1);
      end
      if (pop) begin
        rd_q <= rd_q + FIFO_AW'(1);
      end
      case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + FIFO_CW'(1);
        2'b01:   cnt_q <= cnt_q - FIFO_CW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = slot_q[rd_q];
  assign count_o     = cnt_q;

endmodule

`default_nettype wire

FILE: src/rgb_box_blur_3x3.sv
// top level of the streaming 3x3 rgb box blur
`default_nettype none

// Streaming 3x3 box blur for RGB888 pixels in raster order. It takes one item
// per clock unless the input stalls: each accepted pixel reads two stored rows
// at its column from a single line memory and writes the shifted rows back the
// next cycle, with forwarding covering a back-to-back hit on the same column,
// so narrow frames run at full rate too. A result passes the read stage, the
// window stage and the queue register after the accept of the item that
// completes its window, and waits in a four-entry queue; the input stalls only
// when that queue plus the two items in flight would fill it. Each result lags
// the stream by image_width + 1 positions, so once the frame's pixels are in,
// drain items (cmd = 1) flush the last row, one result each. A register write
// restarts the frame; the user makes it only while the block is idle, which
// the block does not enforce. The line memory needs no clearing after reset.
module rgb_box_blur_3x3 import bb3_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_data_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);

  logic [10:0]        width_q;
  logic [15:0]        height_q;
  logic               cfg_wr;
  logic [WW-1:0]      eff_w;
  logic [15:0]        eff_h;

  logic [CW-1:0]      in_col_q, in_col_d;
  logic [15:0]        in_row_q, in_row_d;
  logic [CW-1:0]      out_col_q, out_col_d;
  logic [15:0]        out_row_q, out_row_d;

  logic               in_acc;
  logic               all_in;
  logic               take;
  logic               ready;
  logic               in_col_wrap;
  logic               out_col_wrap;
  logic               out_row_last;
  logic               last;
  tap_ctrl_t          ctrl_d;
  pix_t               pix_d;

  logic               s1_v_q;
  tap_ctrl_t          s1_ctrl_q;
  pix_t               s1_pix_q;
  logic [CW-1:0]      s1_col_q;
  logic               fwd_v_q;
  logic [LINE_W-1:0]  fwd_data_q;
  logic [LINE_W-1:0]  ram_rdata;
  logic [LINE_W-1:0]  above;
  logic [LINE_W-1:0]  wb_data;

  logic               res_valid;
  out_item_t          res;
  logic [FIFO_CW-1:0] fifo_cnt;
  logic [FIFO_CW:0]   load;

  // register port
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_IMAGE_WIDTH:  width_q  <= pwdata[10:0];
        REG_IMAGE_HEIGHT: height_q <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_IMAGE_WIDTH:  prdata = {21'd0, width_q};
      REG_IMAGE_HEIGHT: prdata = {16'd0, height_q};
    endcase
  end

  // effective frame size
  always_comb begin
    if (width_q == '0) begin
      eff_w = WW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_q);
    end
  end

  assign eff_h = (height_q == '0) ? 16'd1 : height_q;

  // stream position decisions for the item at the input
  assign in_acc       = in_valid_i && !in_stall_o;
  assign all_in       = in_row_q >= eff_h;
  assign take         = in_acc && (all_in || !in_data_i.cmd);
  assign ready        = (in_row_q >= 16'd2) || ((in_row_q == 16'd1) && (in_col_q != '0));
  assign in_col_wrap  = (WW'(in_col_q) + WW'(1)) >= eff_w;
  assign out_col_wrap = (WW'(out_col_q) + WW'(1)) >= eff_w;
  assign out_row_last = ({1'b0, out_row_q} + 17'd1) >= {1'b0, eff_h};
  assign last         = out_row_last && out_col_wrap;

  assign pix_d = all_in ? '0 : {in_data_i.red_in, in_data_i.green_in, in_data_i.blue_in};

  always_comb begin
    ctrl_d.has_res   = ready;
    ctrl_d.frame_end = last;
    ctrl_d.row0_ok   = out_row_q != '0;
    ctrl_d.row2_ok   = !out_row_last;
    ctrl_d.col0_ok   = out_col_q != '0;
    ctrl_d.col2_ok   = !out_col_wrap;
  end

  // position counters, cleared by a register write and at frame end
  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (cfg_wr) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else if (take) begin
      if (in_col_wrap) begin
        in_col_d = '0;
        if (in_row_q != ROW_MAX) begin
          in_row_d = in_row_q + 16'd1;
        end
      end else begin
        in_col_d = in_col_q + CW'(1);
      end
      if (ready) begin
        if (last) begin
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
        end else if (out_col_wrap) begin
          out_col_d = '0;
          out_row_d = out_row_q + 16'd1;
        end else begin
          out_col_d = out_col_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  // read stage control, forward when the previous item writes the same column
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      fwd_v_q <= 1'b0;
    end else begin
      s1_v_q  <= take;
      fwd_v_q <= take && s1_v_q && (s1_col_q == in_col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_ctrl_q  <= ctrl_d;
      s1_pix_q   <= pix_d;
      s1_col_q   <= in_col_q;
      fwd_data_q <= wb_data;
    end
  end

  // write back: middle row moves up, new pixel becomes the middle row
  assign above   = fwd_v_q ? fwd_data_q : ram_rdata;
  assign wb_data = {above[$bits(pix_t)-1:0], s1_pix_q};

  bb3_line_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (LINE_W)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_v_q),
    .waddr_i (s1_col_q),
    .wdata_i (wb_data),
    .re_i    (take),
    .raddr_i (in_col_q),
    .rdata_o (ram_rdata)
  );

  bb3_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .shift_i     (s1_v_q),
    .ctrl_i      (s1_ctrl_q),
    .above2_i    (above[LINE_W-1:$bits(pix_t)]),
    .above1_i    (above[$bits(pix_t)-1:0]),
    .pix_i       (s1_pix_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  bb3_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .count_o     (fifo_cnt)
  );

  // input credit: queued results plus items in flight
  assign load       = {1'b0, fifo_cnt} + (FIFO_CW + 1)'(s1_v_q) + (FIFO_CW + 1)'(res_valid);
  assign in_stall_o = load >= (FIFO_CW + 1)'(FIFO_DEPTH);

endmodule

`default_nettype wire

FILE: src/bb3_checker.sv
// port-level checks for the box blur top level and their binding
`default_nettype none

module bb3_checker import bb3_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  logic in_xfer;

  assign in_xfer = in_valid_i && !in_stall_o;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result changed while stalled");

  // nothing leaves during reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

  // a result follows its input transfer through the read, window and queue registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_xfer, 3))
    else $error("result without matching input transfer");

  // an empty block with nothing in flight takes input
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o && !$past(in_xfer, 1) && !$past(in_xfer, 2)) |-> !in_stall_o)
    else $error("input stalled while block is empty");

endmodule

bind rgb_box_blur_3x3 bb3_checker u_bb3_checker (.*);

`default_nettype wire

FILE: sim/rgb_box_blur_3x3_test.sv
// testbench for the 3x3 rgb box blur: directed table, then random frames checked by a predictor
`timescale 1ns / 100ps

module rgb_box_blur_3x3_test;
  import bb3_pkg::*;

  localparam int unsigned LINE_LEN       = 1024;
  localparam int unsigned SETTLE_CYCLES  = 12;
  localparam int unsigned TAIL_CYCLES    = 20;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int          N_DIRECTED     = 27;
  localparam int unsigned EDGE_PIXELS    = 150;
  localparam int unsigned NO_CAP         = 32'hFFFF_FFFF;

  // input command codes
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef enum logic [1:0] {ROW_ITEM, ROW_WIDTH, ROW_HEIGHT} row_kind_e;

  // one row of the directed table
  typedef struct packed {
    row_kind_e   kind;
    logic [31:0] value;
    in_item_t    item;
    logic        typed;
    logic        has_res;
    out_item_t   res;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data = '0;
  logic        out_valid_o;
  logic        out_stall = 1'b0;
  out_item_t   out_data_o;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned frames_done = 0;
  int unsigned quiet_cycles = 0;

  out_item_t blur_expected [$];

  // predictor state
  logic [10:0] width_reg = WIDTH_RESET;
  logic [15:0] height_reg = HEIGHT_RESET;
  pix_t        row_two_up [LINE_LEN];
  pix_t        row_one_up [LINE_LEN];
  pix_t        win [9];
  logic [9:0]  pos_in_col = '0;
  logic [15:0] pos_in_row = '0;
  logic [9:0]  pos_out_col = '0;
  logic [15:0] pos_out_row = '0;

  rgb_box_blur_3x3 #(.MAX_WIDTH(LINE_LEN)) dut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .in_valid_i (in_valid),
    .in_stall_o,
    .in_data_i  (in_data),
    .out_valid_o,
    .out_stall_i(out_stall),
    .out_data_o
  );

  always #1 clk_i = ~clk_i;

  function automatic int unsigned active_width();
    int unsigned w;
    w = (width_reg == 0) ? 1 : width_reg;
    if (w > LINE_LEN) w = LINE_LEN;
    return w;
  endfunction

  function automatic int unsigned active_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  function automatic void restart_frame();
    pos_in_col = '0;
    pos_in_row = '0;
    pos_out_col = '0;
    pos_out_row = '0;
  endfunction

  function automatic logic [7:0] sat8(int unsigned v);
    return (v > 255) ? 8'hFF : 8'(v);
  endfunction

  // advance the blur state by one item; returns 1 when a result comes out
  function automatic bit blur_step(input in_item_t it, output out_item_t res);
    int unsigned w, h, col, k, r, c, sum_r, sum_g, sum_b;
    bit all_in, ready, tap_ok, last;
    pix_t pix, up2, up1, center, tap;
    w = active_width();
    h = active_height();
    res = '0;
    all_in = pos_in_row >= h;
    // drains are ignored until the whole frame is in
    if (!all_in && it.cmd == CMD_DRAIN) return 0;
    pix = all_in ? '0 : {it.red_in, it.green_in, it.blue_in};
    ready = (pos_in_row >= 2) || (pos_in_row == 1 && pos_in_col >= 1);
    // line stores and window shift
    col = pos_in_col;
    up2 = row_two_up[col];
    up1 = row_one_up[col];
    row_two_up[col] = up1;
    row_one_up[col] = pix;
    for (k = 0; k < 3; k++) begin
      win[3 * k] = win[3 * k + 1];
      win[3 * k + 1] = win[3 * k + 2];
    end
    win[2] = up2;
    win[5] = up1;
    win[8] = pix;
    if (pos_in_col + 1 >= w) begin
      pos_in_col = '0;
      if (pos_in_row != ROW_MAX) pos_in_row++;
    end else begin
      pos_in_col++;
    end
    if (!ready) return 0;
    // taps outside the image take the center value
    center = win[4];
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    for (k = 0; k < 9; k++) begin
      r = k / 3;
      c = k % 3;
      tap_ok = (r != 0 || pos_out_row >= 1) && (r != 2 || pos_out_row + 1 < h)
            && (c != 0 || pos_out_col >= 1) && (c != 2 || pos_out_col + 1 < w);
      tap = tap_ok ? win[k] : center;
      sum_r += tap[23:16] >> 3;
      sum_g += tap[15:8] >> 3;
      sum_b += tap[7:0] >> 3;
    end
    res.red_out = sat8(sum_r);
    res.green_out = sat8(sum_g);
    res.blue_out = sat8(sum_b);
    last = (pos_out_row + 1 >= h) && (pos_out_col + 1 >= w);
    res.frame_end = last;
    if (last) begin
      restart_frame();
    end else if (pos_out_col + 1 >= w) begin
      pos_out_col = '0;
      pos_out_row++;
    end else begin
      pos_out_col++;
    end
    return 1;
  endfunction

  function automatic in_item_t make_item(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    in_item_t it;
    it.cmd = cmd;
    it.red_in = r;
    it.green_in = g;
    it.blue_in = b;
    return it;
  endfunction

  // channel values biased toward the extremes so saturation shows up
  function automatic logic [7:0] rand_chan();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 4) return 8'hFF;
    if (pick < 6) return 8'h00;
    if (pick < 9) return 8'($urandom_range(232, 255));
    return 8'($urandom);
  endfunction

  function automatic in_item_t rand_item(logic cmd);
    return make_item(cmd, rand_chan(), rand_chan(), rand_chan());
  endfunction

  function automatic dir_row_t cfg_row(row_kind_e kind, logic [31:0] value);
    dir_row_t row;
    row = '0;
    row.kind = kind;
    row.value = value;
    return row;
  endfunction

  function automatic dir_row_t item_row(in_item_t it);
    dir_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.item = it;
    return row;
  endfunction

  function automatic dir_row_t known_row(in_item_t it, logic has, logic [7:0] r, logic [7:0] g,
                                         logic [7:0] b, logic fe);
    dir_row_t row;
    row = item_row(it);
    row.typed = 1'b1;
    row.has_res = has;
    row.res.red_out = r;
    row.res.green_out = g;
    row.res.blue_out = b;
    row.res.frame_end = fe;
    return row;
  endfunction

  // directed stimulus
  function automatic dir_row_t directed_row(int idx);
    case (idx)
      // one-pixel frame: result needs two drains, the first one is early
      0:  return cfg_row(ROW_WIDTH, 32'd1);
      1:  return cfg_row(ROW_HEIGHT, 32'd1);
      2:  return known_row(make_item(CMD_PIXEL, 8'd255, 8'd0, 8'd8), 0, 0, 0, 0, 0);
      3:  return known_row(make_item(CMD_DRAIN, 8'd0, 8'd0, 8'd0), 0, 0, 0, 0, 0);
      4:  return known_row(make_item(CMD_DRAIN, 8'd0, 8'd0, 8'd0), 1, 8'd255, 8'd0, 8'd9, 1);
      // drain at the start of a frame does nothing
      5:  return known_row(make_item(CMD_DRAIN, 8'hFF, 8'hFF, 8'hFF), 0, 0, 0, 0, 0);
      6:  return known_row(make_item(CMD_PIXEL, 8'd64, 8'd128, 8'd16), 0, 0, 0, 0, 0);
      // pixels past the frame act as drains
      7:  return known_row(make_item(CMD_PIXEL, 8'd7, 8'd7, 8'd7), 0, 0, 0, 0, 0);
      8:  return known_row(make_item(CMD_PIXEL, 8'd1, 8'd1, 8'd1), 1, 8'd72, 8'd144, 8'd18, 1);
      // zero sizes behave as one
      9:  return cfg_row(ROW_WIDTH, 32'd0);
      10: return cfg_row(ROW_HEIGHT, 32'd0);
      11: return known_row(make_item(CMD_PIXEL, 8'd248, 8'd249, 8'd250), 0, 0, 0, 0, 0);
      12: return known_row(make_item(CMD_DRAIN, 8'd0, 8'd0, 8'd0), 0, 0, 0, 0, 0);
      13: return known_row(make_item(CMD_DRAIN, 8'd0, 8'd0, 8'd0), 1, 8'd255, 8'd255, 8'd255, 1);
      // small 3x2 frame with an ignored drain inside
      14: return cfg_row(ROW_WIDTH, 32'd3);
      15: return cfg_row(ROW_HEIGHT, 32'd2);
      16: return item_row(make_item(CMD_PIXEL, 8'd255, 8'd255, 8'd255));
      17: return item_row(make_item(CMD_PIXEL, 8'd0, 8'd0, 8'd0));
      18: return item_row(make_item(CMD_DRAIN, 8'd0, 8'd0, 8'd0));
      19: return item_row(make_item(CMD_PIXEL, 8'd128, 8'd64, 8'd32));
      20: return item_row(make_item(CMD_PIXEL, 8'd8, 8'd16, 8'd24));
      21: return item_row(make_item(CMD_PIXEL, 8'd200, 8'd100, 8'd50));
      22: return item_row(make_item(CMD_PIXEL, 8'd255, 8'd0, 8'd255));
      default: return item_row(make_item(CMD_DRAIN, 8'd0, 8'd0, 8'd0));
    endcase
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // one input transfer, with random source gaps before it
  task automatic drive_item(in_item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic send_item(in_item_t it);
    out_item_t res;
    if (blur_step(it, res)) blur_expected.push_back(res);
    drive_item(it);
  endtask

  // wait for all results and let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (blur_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // register write followed by a read back
  task automatic write_reg(logic idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_IMAGE_WIDTH) width_reg = value[10:0];
    else height_reg = value[15:0];
    restart_frame();
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_IMAGE_WIDTH) check_field("image_width", {21'd0, width_reg}, prdata);
    else check_field("image_height", {16'd0, height_reg}, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // new frame size, junk in the unused upper data bits
  task automatic set_frame(logic [10:0] w_raw, logic [15:0] h_raw);
    settle();
    write_reg(REG_IMAGE_WIDTH, ($urandom & 32'hFFFF_F800) | {21'd0, w_raw});
    write_reg(REG_IMAGE_HEIGHT, ($urandom & 32'hFFFF_0000) | {16'd0, h_raw});
  endtask

  function automatic logic [10:0] pick_width();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) return 11'd0;
    if (pick < 70) return 11'($urandom_range(1, 6));
    return 11'($urandom_range(7, 40));
  endfunction

  function automatic logic [15:0] pick_height();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) return 16'd0;
    if (pick < 80) return 16'($urandom_range(1, 5));
    return 16'($urandom_range(6, 12));
  endfunction

  // one frame of pixels with stray drains, then the flush; sometimes cut short
  task automatic send_frame(input bit may_cut, input int unsigned max_pix, output bit cut,
                            output int unsigned n_sent);
    int unsigned w, n_pix, stop, i;
    w = active_width();
    n_pix = w * active_height();
    stop = n_pix;
    cut = 0;
    n_sent = 0;
    if (may_cut && $urandom_range(0, 15) == 0) begin
      stop = $urandom_range(0, n_pix - 1);
      cut = 1;
    end
    // very large frames stop early, the next register write restarts them
    if (stop > max_pix) begin
      stop = max_pix;
      cut = 1;
    end
    for (i = 0; i < stop; i++) begin
      if ($urandom_range(0, 19) == 0) send_item(rand_item(CMD_DRAIN));
      send_item(rand_item(CMD_PIXEL));
      n_sent++;
    end
    if (!cut) begin
      for (i = 0; i <= w; i++) begin
        send_item(rand_item(($urandom_range(0, 9) < 7) ? CMD_DRAIN : CMD_PIXEL));
        n_sent++;
      end
    end
  endtask

  task automatic run_phase(int unsigned idle, int unsigned stall, int unsigned quota,
                           logic [10:0] edge_w, logic [15:0] edge_h);
    int unsigned done, n;
    bit cut;
    settle();
    idle_pct = idle;
    stall_pct = stall;
    // one frame at an extreme size first
    set_frame(edge_w, edge_h);
    send_frame(0, EDGE_PIXELS, cut, n);
    done = 0;
    while (done < quota) begin
      if (cut || $urandom_range(0, 1) == 0) set_frame(pick_width(), pick_height());
      send_frame(1, NO_CAP, cut, n);
      done += n;
    end
  endtask

  // result checking, sink stalls and watchdog
  always @(posedge clk_i) begin : result_monitor
    out_item_t want;
    out_stall <= ($urandom_range(0, 99) < stall_pct);
    if (rst_ni && out_valid_o && !out_stall) begin
      results_checked++;
      if (blur_expected.size() == 0) begin
        $error("result transfer with no expected result pending");
        mismatches++;
      end else begin
        want = blur_expected.pop_front();
        check_field("red_out", want.red_out, out_data_o.red_out);
        check_field("green_out", want.green_out, out_data_o.green_out);
        check_field("blue_out", want.blue_out, out_data_o.blue_out);
        check_field("frame_end", want.frame_end, out_data_o.frame_end);
        if (want.frame_end) frames_done++;
      end
    end
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int i;
    dir_row_t row;
    out_item_t res;
    bit got;
    foreach (row_two_up[k]) begin
      row_two_up[k] = '0;
      row_one_up[k] = '0;
    end
    foreach (win[k]) win[k] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (i = 0; i < N_DIRECTED; i++) begin
      row = directed_row(i);
      case (row.kind)
        ROW_WIDTH: begin
          settle();
          write_reg(REG_IMAGE_WIDTH, row.value);
        end
        ROW_HEIGHT: begin
          settle();
          write_reg(REG_IMAGE_HEIGHT, row.value);
        end
        default: begin
          got = blur_step(row.item, res);
          if (row.typed) begin
            got = row.has_res;
            res = row.res;
          end
          if (got) blur_expected.push_back(res);
          drive_item(row.item);
        end
      endcase
    end

    // random frames under each gap and stall mix
    run_phase(0, 0, 350, 11'd1, 16'hFFFF);
    run_phase(59, 0, 350, 11'd2047, 16'd2);
    run_phase(0, 59, 350, 11'd1024, 16'd1);
    run_phase(18, 18, 350, 11'd2, 16'd0);

    // drain and finish
    in_valid <= 1'b0;
    while (blur_expected.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("%0d input transfers, %0d result transfers, %0d frames ended",
             items_sent, results_checked, frames_done);
    $display("frame sizes from zero to all ones, four mixes of source gaps and sink stalls");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
src/bb3_pkg.sv
src/bb3_line_ram.sv
src/bb3_window.sv
src/bb3_out_fifo.sv
src/rgb_box_blur_3x3.sv
src/bb3_checker.sv
sim/rgb_box_blur_3x3_test.sv
